/* sv/hdom_pkg.sv */
// shared types and constants for the height to du/dv offset map block
// no dependencies
package hdom_pkg;

    localparam int DIM_W   = 9;
    localparam int COORD_W = 8;
    localparam int HGT_W   = 8;
    localparam int PIX_W   = 32;
    localparam int SEL_W   = 2;
    localparam int IDX_W   = 2;
    localparam int OFS_W   = 8;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_CHANNEL_SELECT = 2'd2;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH    = 9'd256;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT   = 9'd256;
    localparam logic [SEL_W-1:0] RST_CHANNEL_SELECT = 2'd0;

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // effective image configuration, dimensions already clamped
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [SEL_W-1:0] chan_sel;
    } t_cfg;

endpackage

/* sv/hdom_ram.sv */
// generic single-port synchronous ram, registered read data
// no dependencies
module hdom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic                                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                     i_wdata,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/hdom_core.sv */
// request sequencer: stores heights and reads four wrapped neighbours per compute
// depends on hdom_pkg and hdom_ram
module hdom_core #(
    parameter int MAX_WIDTH  = hdom_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hdom_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hdom_pkg::t_cfg                    i_cfg,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [hdom_pkg::COORD_W-1:0]      i_col,
    input  logic [hdom_pkg::COORD_W-1:0]      i_row,
    input  logic [hdom_pkg::PIX_W-1:0]        i_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [hdom_pkg::OFS_W-1:0] o_du,
    output logic signed [hdom_pkg::OFS_W-1:0] o_dv,
    output logic                              o_bad_coord
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = hdom_pkg::DIM_W;
    localparam int HW    = hdom_pkg::HGT_W;

    typedef enum logic [1:0] {S_IDLE, S_WR, S_RD, S_LAST} t_state;

    t_state                r_state;
    logic [1:0]            r_cnt;
    logic [DW-1:0]         r_c, r_r, r_cl, r_cr, r_ru, r_rd;
    logic [HW-1:0]         r_wbyte;
    logic [HW-1:0]         r_h_l, r_h_r, r_h_u;
    logic                  r_bad;
    logic                  r_out_valid;
    logic signed [hdom_pkg::OFS_W-1:0] r_du, r_dv;
    logic                  r_out_bad;

    logic [DW-1:0]         n_c, n_r, n_cl, n_cr, n_ru, n_rd;
    logic                  n_inside;
    logic                  w_take, w_out_free;
    logic [DW-1:0]         w_arow, w_acol;
    logic [31:0]           w_afull;
    logic [AW-1:0]         w_addr;
    logic                  w_we, w_re;
    logic [HW-1:0]         w_rdata;
    logic signed [hdom_pkg::OFS_W-1:0] w_du, w_dv;

    // (a - b) / 2 truncated toward zero
    function automatic logic signed [7:0] half_diff(input logic [7:0] a, input logic [7:0] b);
        logic signed [9:0] d;
        logic signed [9:0] q;
        d = $signed({2'b00, a}) - $signed({2'b00, b});
        q = (d + $signed({9'd0, d[9]})) >>> 1;
        return q[7:0];
    endfunction

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_LAST) && w_out_free);
    assign w_take     = i_in_valid && o_in_ready;

    // wrapped neighbour coordinates of the incoming request
    always_comb begin
        n_c      = {1'b0, i_col};
        n_r      = {1'b0, i_row};
        n_inside = (n_c < i_cfg.width) && (n_r < i_cfg.height);
        n_cl     = (n_c == '0) ? i_cfg.width - 1'b1 : n_c - 1'b1;
        n_cr     = (n_c == i_cfg.width - 1'b1) ? '0 : n_c + 1'b1;
        n_ru     = (n_r == '0) ? i_cfg.height - 1'b1 : n_r - 1'b1;
        n_rd     = (n_r == i_cfg.height - 1'b1) ? '0 : n_r + 1'b1;
    end

    // read order: left, right, upper, lower
    always_comb begin
        w_arow = r_r;
        w_acol = r_c;
        if (r_state == S_RD) begin
            case (r_cnt)
                2'd0:    begin w_arow = r_r;  w_acol = r_cl; end
                2'd1:    begin w_arow = r_r;  w_acol = r_cr; end
                2'd2:    begin w_arow = r_ru; w_acol = r_c;  end
                default: begin w_arow = r_rd; w_acol = r_c;  end
            endcase
        end
    end

    assign w_afull = 32'(w_arow) * 32'(MAX_WIDTH) + 32'(w_acol);
    assign w_addr  = w_afull[AW-1:0];
    assign w_we    = (r_state == S_WR);
    assign w_re    = (r_state == S_RD);

    hdom_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_height_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (r_wbyte),
        .o_rdata (w_rdata)
    );

    assign w_du = half_diff(r_h_l, r_h_r);
    assign w_dv = half_diff(r_h_u, w_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_WR: begin
                    r_state <= S_IDLE;
                end
                S_RD: begin
                    // data of the previous read arrives this cycle
                    case (r_cnt)
                        2'd1:    r_h_l <= w_rdata;
                        2'd2:    r_h_r <= w_rdata;
                        2'd3:    r_h_u <= w_rdata;
                        default: ;
                    endcase
                    if (r_cnt == 2'd3) begin
                        r_state <= S_LAST;
                    end
                    r_cnt <= r_cnt + 2'd1;
                end
                S_LAST: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_bad   <= r_bad;
                        r_du        <= r_bad ? '0 : w_du;
                        r_dv        <= r_bad ? '0 : w_dv;
                        r_state     <= S_IDLE;
                    end
                end
                default: ;
            endcase
            if (w_take) begin
                r_c     <= n_c;
                r_r     <= n_r;
                r_cl    <= n_cl;
                r_cr    <= n_cr;
                r_ru    <= n_ru;
                r_rd    <= n_rd;
                r_wbyte <= i_pixel[{i_cfg.chan_sel, 3'b000} +: HW];
                r_bad   <= !n_inside;
                r_cnt   <= '0;
                if (i_op == hdom_pkg::OP_STORE) begin
                    r_state <= n_inside ? S_WR : S_IDLE;
                end else begin
                    r_state <= n_inside ? S_RD : S_LAST;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_du        = r_du;
    assign o_dv        = r_dv;
    assign o_bad_coord = r_out_bad;

`ifndef SYNTH
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("height ram written and read in the same cycle");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_LAST))
        else $error("result appeared outside the final step");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_coord) |-> (o_du == '0 && o_dv == '0))
        else $error("flagged result carries nonzero offsets");

    a_compute_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_op == hdom_pkg::OP_COMPUTE && n_inside)
            |=> (r_state == S_RD && r_cnt == 2'd0))
        else $error("valid compute request did not start neighbour reads");
`endif

endmodule

/* sv/height_to_dudv_offset_map.sv */
// height image to du/dv offset map: a store request is written to the height ram in
// the S_WR state; a compute request reads the 4 neighbours on one ram port in S_RD,
// then registers the subtract from S_LAST; a flagged compute goes straight to S_LAST.
// the next compute is taken in S_LAST itself once the output register is free.
// synchronous active-low reset clears control and restores the configuration
// registers; the height ram is not cleared. depends on hdom_pkg and hdom_core
module height_to_dudv_offset_map #(
    parameter int MAX_WIDTH  = hdom_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hdom_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hdom_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [hdom_pkg::DIM_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [hdom_pkg::COORD_W-1:0]      i_col,
    input  logic [hdom_pkg::COORD_W-1:0]      i_row,
    input  logic [hdom_pkg::PIX_W-1:0]        i_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [hdom_pkg::OFS_W-1:0] o_du,
    output logic signed [hdom_pkg::OFS_W-1:0] o_dv,
    output logic                              o_bad_coord
);

    logic [hdom_pkg::DIM_W-1:0] r_image_width;
    logic [hdom_pkg::DIM_W-1:0] r_image_height;
    logic [hdom_pkg::SEL_W-1:0] r_channel_select;
    hdom_pkg::t_cfg             w_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= hdom_pkg::RST_IMAGE_WIDTH;
            r_image_height   <= hdom_pkg::RST_IMAGE_HEIGHT;
            r_channel_select <= hdom_pkg::RST_CHANNEL_SELECT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hdom_pkg::CFG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data;
                hdom_pkg::CFG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_data;
                hdom_pkg::CFG_CHANNEL_SELECT: r_channel_select <= i_cfg_data[hdom_pkg::SEL_W-1:0];
                default: ;
            endcase
        end
    end

    // dimensions above the store size act as the store size
    always_comb begin
        w_cfg.width    = (32'(r_image_width) > MAX_WIDTH) ?
                         hdom_pkg::DIM_W'(MAX_WIDTH) : r_image_width;
        w_cfg.height   = (32'(r_image_height) > MAX_HEIGHT) ?
                         hdom_pkg::DIM_W'(MAX_HEIGHT) : r_image_height;
        w_cfg.chan_sel = r_channel_select;
    end

    hdom_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_du        (o_du),
        .o_dv        (o_dv),
        .o_bad_coord (o_bad_coord)
    );

endmodule
